/* hw/rtl/kpsd_pkg.sv */
// Shared types and constants for the keypad scan debouncer.
package kpsd_pkg;

    // Default matrix geometry.
    localparam int MATRIX_ROWS_DEF = 5;
    localparam int MATRIX_COLS_DEF = 3;

    // Key slots, widths and the largest matrix key count.
    localparam int KEY_SLOTS    = 16;
    localparam int SLOT_W       = 4;
    localparam int KEY_W        = 5;
    localparam int CNT_W        = 4;
    localparam int MATRIX_W     = 15;
    localparam int MAX_MATRIX   = 15;

    // Debounce threshold after reset.
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd10;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Result of visiting one key slot.
    typedef struct packed {
        logic             changed;
        logic             new_stable;
        logic [CNT_W-1:0] new_count;
    } t_visit;

endpackage

/* hw/rtl/keypad_scan_debouncer_top.sv */
// Top level of the keypad scan debouncer: sequencer, key state and output register.
// Each accepted word is one scan sample. The sequencer then visits the key slots one per
// cycle through a single shared debounce unit, matrix keys first and the extra key last,
// and stops at the first key that has just become stably pressed. A sample therefore
// visits from 1 up to min(MATRIX_ROWS*MATRIX_COLS, 15) + 1 slots. The result is then handed
// to the output register and the sequencer returns to idle, provided the consumer has taken
// the previous result by the time this one is handed over; otherwise the hand-over waits
// until it does. The input is stalled from the moment a sample is accepted until its result
// has been handed over; the output register lets a result wait for the consumer while the
// next sample is accepted.
// The result word is the key number, or 0 when no key was newly pressed.
module keypad_scan_debouncer_top
    import kpsd_pkg::*;
#(
    parameter int MATRIX_ROWS = MATRIX_ROWS_DEF,
    parameter int MATRIX_COLS = MATRIX_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CNT_W-1:0]    i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MATRIX_W-1:0] i_matrix_levels,
    input  logic                i_aux_level,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [KEY_W-1:0]    o_pressed_key
);

    localparam int KEY_PRODUCT = MATRIX_ROWS * MATRIX_COLS;
    localparam int MATRIX_KEYS = (KEY_PRODUCT > MAX_MATRIX) ? MAX_MATRIX : KEY_PRODUCT;
    localparam logic [SLOT_W-1:0] AUX_SLOT = SLOT_W'(MATRIX_KEYS);

    t_state r_state, n_state;

    logic [CNT_W-1:0]    r_threshold;
    logic [MATRIX_W-1:0] r_levels;
    logic                r_aux;
    logic [SLOT_W-1:0]   r_slot;
    logic [KEY_W-1:0]    r_result;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_key;

    logic [KEY_SLOTS-1:0] r_stable;
    logic [CNT_W-1:0]     r_count [KEY_SLOTS];

    logic             in_accept;
    logic             out_free;
    logic             is_aux;
    logic             slot_level;
    logic             pressed;
    logic             scan_end;
    logic             load_out;
    t_visit           visit;
    logic [MATRIX_W:0] levels_ext;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    // Level of the slot under visit; the extra key is the last slot.
    assign levels_ext = {1'b0, r_levels};
    assign is_aux     = (r_slot == AUX_SLOT);
    assign slot_level = is_aux ? r_aux : levels_ext[r_slot];

    kpsd_key_unit u_key_unit (
        .i_level     (slot_level),
        .i_stable    (r_stable[r_slot]),
        .i_count     (r_count[r_slot]),
        .i_threshold (r_threshold),
        .o_visit     (visit)
    );

    // A matrix key is pressed at level 1, the pulled-up extra key at level 0.
    assign pressed  = visit.changed && (slot_level == !is_aux);
    assign scan_end = pressed || is_aux;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept) n_state = ST_SCAN;
            ST_SCAN: if (scan_end) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall  = 1'b1;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_stall  = 1'b0;
            ST_DONE: load_out = out_free;
            default: begin
                o_stall  = 1'b1;
                load_out = 1'b0;
            end
        endcase
    end

    // State register and debounce threshold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_threshold <= THRESHOLD_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    // Sample capture, slot counter and scan result.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_levels <= i_matrix_levels;
            r_aux    <= i_aux_level;
            r_slot   <= '0;
        end else if (r_state == ST_SCAN) begin
            r_slot <= r_slot + SLOT_W'(1);
            if (pressed) begin
                r_result <= KEY_W'(r_slot) + KEY_W'(1);
            end else if (is_aux) begin
                r_result <= '0;
            end
        end
    end

    // Per-key stable level and disagreement counter, written by the shared unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else if (r_state == ST_SCAN) begin
            r_stable[r_slot] <= visit.new_stable;
            r_count[r_slot]  <= visit.new_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_key <= r_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pressed_key = r_out_key;

endmodule

/* hw/rtl/kpsd_key_unit.sv */
// Shared per-key debounce unit: compare, count and threshold test for one slot.
module kpsd_key_unit
    import kpsd_pkg::*;
(
    input  logic             i_level,
    input  logic             i_stable,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_threshold,
    output t_visit           o_visit
);

    logic [CNT_W-1:0] thr_eff;
    logic [CNT_W-1:0] count_inc;

    // A threshold of zero acts as one; the counter wraps at its width.
    assign thr_eff   = (i_threshold == '0) ? CNT_W'(1) : i_threshold;
    assign count_inc = i_count + CNT_W'(1);

    // Matching sample clears the count; a count reaching the threshold flips the level.
    always_comb begin
        o_visit.changed    = 1'b0;
        o_visit.new_stable = i_stable;
        o_visit.new_count  = '0;
        if (i_level != i_stable) begin
            if (count_inc >= thr_eff) begin
                o_visit.changed    = 1'b1;
                o_visit.new_stable = i_level;
            end else begin
                o_visit.new_count = count_inc;
            end
        end
    end

endmodule

/* bench/kpsd_checker.sv */
// Checker for the keypad scan debouncer: predicts every result word and compares it.
module kpsd_checker
    import kpsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CNT_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [MATRIX_W-1:0] i_matrix_levels,
    input  logic                i_aux_level,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [KEY_W-1:0]    i_pressed_key,
    output int                  o_pending,
    output int                  o_failures
);

    // Matrix keys of the default geometry; the extra key follows them.
    localparam int MATRIX_KEYS = (MATRIX_ROWS_DEF * MATRIX_COLS_DEF > MAX_MATRIX) ?
                                 MAX_MATRIX : MATRIX_ROWS_DEF * MATRIX_COLS_DEF;

    logic [CNT_W-1:0] threshold = THRESHOLD_RESET;
    logic             key_stable [KEY_SLOTS];
    logic [CNT_W-1:0] key_count  [KEY_SLOTS];
    logic [KEY_W-1:0] expected_keys [$];
    int               failures = 0;

    // Debounces one key slot and returns 1 when its stable level has just changed.
    function automatic logic settle_key(input int slot, input logic level);
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] next_count;
        if (level == key_stable[slot]) begin
            key_count[slot] = '0;
            return 1'b0;
        end
        // A zero threshold acts as one.
        limit = (threshold == '0) ? CNT_W'(1) : threshold;
        next_count = key_count[slot] + CNT_W'(1);
        if (next_count >= limit) begin
            key_stable[slot] = level;
            key_count[slot] = '0;
            return 1'b1;
        end
        key_count[slot] = next_count;
        return 1'b0;
    endfunction

    // Visits the keys in order and returns the first newly pressed one, or 0.
    function automatic logic [KEY_W-1:0] scan_sample(input logic [MATRIX_W-1:0] levels,
                                                      input logic aux);
        for (int k = 0; k < MATRIX_KEYS; k++) begin
            if (settle_key(k, levels[k]) && levels[k])
                return KEY_W'(k + 1);
        end
        // The extra key is pulled up, so a low level means pressed.
        if (settle_key(MATRIX_KEYS, aux) && !aux)
            return KEY_W'(MATRIX_KEYS + 1);
        return '0;
    endfunction

    // Track configuration, check result words, then predict from accepted samples.
    always @(posedge i_clk) begin : watch
        logic [KEY_W-1:0] want;
        if (!i_rst_n) begin
            threshold = THRESHOLD_RESET;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                key_stable[s] = 1'b0;
                key_count[s] = '0;
            end
            expected_keys.delete();
        end else begin
            if (i_cfg_we)
                threshold = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_keys.size() == 0) begin
                    $display("%0t: key word %0d arrived with nothing expected",
                             $time, i_pressed_key);
                    failures++;
                end else begin
                    want = expected_keys.pop_front();
                    if (i_pressed_key !== want) begin
                        $display("%0t: pressed key expected %0d, got %0d",
                                 $time, want, i_pressed_key);
                        failures++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_keys.push_back(scan_sample(i_matrix_levels, i_aux_level));
        end
        o_pending <= expected_keys.size();
        o_failures <= failures;
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the keypad scan debouncer: clock, reset, stimulus and verdict.
module tb_top;
    import kpsd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 20;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [MATRIX_W-1:0] i_matrix_levels = '0;
    logic                i_aux_level = 1'b1;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [KEY_W-1:0]    o_pressed_key;

    int pending;
    int failures;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    keypad_scan_debouncer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_matrix_levels (i_matrix_levels),
        .i_aux_level     (i_aux_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pressed_key   (o_pressed_key)
    );

    kpsd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_matrix_levels (i_matrix_levels),
        .i_aux_level     (i_aux_level),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_pressed_key   (o_pressed_key),
        .o_pending       (pending),
        .o_failures      (failures)
    );

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The consumer stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one scan sample, with random idle cycles first, and waits until it is taken.
    task automatic send_sample(input logic [MATRIX_W-1:0] levels, input logic aux);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_matrix_levels <= levels;
        i_aux_level <= aux;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stops sending and waits until every predicted word has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the debounce threshold while the block is idle.
    task automatic write_threshold(input logic [CNT_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase: patterns held for about the threshold, with occasional glitches.
    task automatic run_phase(input logic [CNT_W-1:0] thr, input int send_pct,
                             input int recv_pct, input int count);
        int                  sent;
        int                  hold;
        int                  a;
        int                  b;
        logic [MATRIX_W-1:0] pattern;
        logic [MATRIX_W-1:0] levels;
        logic                aux_pattern;
        logic                aux;
        write_threshold(thr);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < count) begin
            pattern = '0;
            case ($urandom_range(3))
                0: pattern = '0;
                1: pattern[$urandom_range(MATRIX_W-1)] = 1'b1;
                2: begin
                    a = $urandom_range(MATRIX_W-1);
                    b = $urandom_range(MATRIX_W-1);
                    pattern[a] = 1'b1;
                    pattern[b] = 1'b1;
                end
                default: pattern = MATRIX_W'($urandom);
            endcase
            aux_pattern = ($urandom_range(3) != 0);
            hold = $urandom_range(1, ((thr == '0) ? 1 : int'(thr)) + 2);
            for (int j = 0; j < hold && sent < count; j++) begin
                levels = pattern;
                aux = aux_pattern;
                // Occasional glitch on one key.
                if ($urandom_range(9) == 0) begin
                    levels[$urandom_range(MATRIX_W-1)] ^= 1'b1;
                    aux ^= 1'($urandom_range(1));
                end
                send_sample(levels, aux);
                sent++;
            end
        end
    endtask

    // Reset, directed samples, random phases and the verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default threshold: four released samples leave the extra key counting.
        repeat (4) send_sample('0, 1'b1);
        // Lowering the threshold below the count takes effect on the next sample.
        write_threshold(CNT_W'(1));
        send_sample('0, 1'b1);
        // All matrix keys held: one key is reported per sample, in order.
        repeat (MAX_MATRIX) send_sample('1, 1'b1);
        // Extra key pressed last.
        send_sample('1, 1'b0);
        // Releasing every key reports nothing.
        send_sample('0, 1'b1);

        run_phase(CNT_W'(1), 0, 0, 200);
        run_phase(CNT_W'(3), 72, 0, 150);
        run_phase(CNT_W'(15), 0, 72, 200);
        run_phase(CNT_W'(0), 36, 36, 150);
        run_phase(CNT_W'(7), 0, 0, 200);
        run_phase(THRESHOLD_RESET, 36, 36, 150);

        drain_results();
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
